// ===== rtl/tlca_pkg.sv =====
// Shared types, sizes and codes of the tree LCA engine.
package tlca_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int LOG_LEVELS   = 10;
  localparam int FW           = 10;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int ADJ_SLOTS    = 2 * (MAX_VERTICES - 1);
  localparam int SW           = $clog2(ADJ_SLOTS + 1);
  localparam int KW           = $clog2(LOG_LEVELS + 1);
  localparam int DEPW         = 10;
  localparam int PLW          = 11;
  localparam int CFG_AW       = 3;

  typedef logic [SW-1:0]   slot_t;
  typedef logic [VW:0]     anc_t;
  typedef logic [FW:0]     pedge_t;
  typedef logic [DEPW-1:0] depth_t;

  localparam slot_t  SLOT_NIL  = '1;
  localparam anc_t   ANC_NIL   = '1;
  localparam pedge_t PEDGE_NIL = '1;

  localparam logic [0:0] REG_ROOT = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    slot_t                     head;
    slot_t                     tail;
    depth_t                    depth;
    pedge_t                    pedge;
    anc_t [LOG_LEVELS-1:0]     anc;
  } vrow_t;

  localparam vrow_t VROW_RESET = '{head: SLOT_NIL, tail: SLOT_NIL, depth: '0,
                                   pedge: PEDGE_NIL, anc: '1};

  typedef struct packed {
    logic [VW-1:0] nbr;
    logic [FW-1:0] num;
  } sdat_t;

  typedef struct packed {
    logic [FW-1:0]   lca_vertex;
    logic [PLW-1:0]  path_length;
    logic            probe_on_path;
    logic            has_parent;
    logic [FW-1:0]   parent_of_a;
    logic [FW-1:0]   parent_edge_of_a;
    logic [DEPW-1:0] depth_of_a;
  } result_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_A_RD, S_A_UPD,
    S_W_INIT, S_W_POP, S_W_CUR0, S_W_CUR1, S_W_SLOT, S_W_NB0, S_W_NB1,
    S_F_RD, S_F_UP, S_F_WR,
    S_M_RDU, S_M_RDV, S_M_SWP, S_M_LIFT, S_M_LIFT2, S_M_CHK,
    S_M_SRU, S_M_SRV, S_M_SRC, S_M_FIN, S_M_FIN2, S_M_DONE, S_M_DM, S_M_DIST,
    S_Q_OUT
  } state_t;

endpackage

// ===== rtl/tlca_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module tlca_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tlca_engine.sv =====
// Sequencer for edge insertion, tree walk, ancestor fill and LCA queries.
module tlca_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tlca_pkg::VW-1:0]     root,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tlca_pkg::op_t               in_op,
  input  logic [tlca_pkg::VW-1:0]     in_a,
  input  logic [tlca_pkg::VW-1:0]     in_b,
  input  logic [tlca_pkg::FW-1:0]     in_num,
  input  logic [tlca_pkg::VW-1:0]     in_p,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tlca_pkg::result_t           out_res
);
  import tlca_pkg::*;

  state_t state_r, state_nxt;

  logic [VW-1:0]   vi_r, vi_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  slot_t           fill_r, fill_nxt;
  logic [VW:0]     top_r, top_nxt;
  logic [VW:0]     pops_r, pops_nxt;
  logic [VW-1:0]   cur_r, cur_nxt;
  anc_t            cur_anc0_r, cur_anc0_nxt;
  depth_t          cur_depth_r, cur_depth_nxt;
  slot_t           s_r, s_nxt;
  logic [VW-1:0]   nx_r, nx_nxt;
  logic [FW-1:0]   num_r, num_nxt;
  logic [VW-1:0]   src_r, src_nxt, dst_r, dst_nxt;
  logic            half_r, half_nxt;
  logic [VW-1:0]   ea_r, ea_nxt, eb_r, eb_nxt, ep_r, ep_nxt;
  logic [FW-1:0]   enum_r, enum_nxt;
  vrow_t           row_r, row_nxt;
  logic [VW-1:0]   qu_r, qu_nxt, qv_r, qv_nxt;
  depth_t          du_r, du_nxt;
  depth_t          diff_r, diff_nxt;
  logic [DEPW+1:0] dsum_r, dsum_nxt;
  anc_t            meet_r, meet_nxt, meet0_r, meet0_nxt;
  depth_t          dm_r, dm_nxt;
  anc_t            au_r, au_nxt;
  logic [1:0]      pass_r, pass_nxt;
  logic [PLW-1:0]  dist0_r, dist0_nxt, dist1_r, dist1_nxt, dist2_r, dist2_nxt;
  anc_t            a_anc0_r, a_anc0_nxt;
  pedge_t          a_pedge_r, a_pedge_nxt;
  depth_t          a_depth_r, a_depth_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_res_r, out_res_nxt;

  logic                   v_we;
  logic [VW-1:0]          v_waddr, v_raddr;
  vrow_t                  v_wdata, v_rdata;
  logic [$bits(vrow_t)-1:0] v_rdata_raw;
  logic                   sd_we, sn_we;
  slot_t                  sd_waddr, sn_waddr, s_raddr, sn_wdata, sn_rdata;
  sdat_t                  sd_wdata, sd_rdata;
  logic [$bits(sdat_t)-1:0] sd_rdata_raw;
  logic                   k_we;
  logic [VW-1:0]          k_waddr, k_raddr, k_wdata, k_rdata;

  logic            add_room, pop_ok, vi_last, fill_last, link_ok, meet_pair;
  logic [KW-1:0]   k_prev;
  logic [VW:0]     top_dec;
  anc_t            w_anc, up_anc;
  logic [DEPW+2:0] d_full;
  logic [PLW-1:0]  d_clamp;
  logic [PLW:0]    probe_sum;

  tlca_ram #(.W($bits(vrow_t)), .D(MAX_VERTICES)) u_vmem (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata_raw)
  );
  tlca_ram #(.W($bits(sdat_t)), .D(ADJ_SLOTS)) u_sdat (
    .clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
    .raddr(s_raddr), .rdata(sd_rdata_raw)
  );
  tlca_ram #(.W(SW), .D(ADJ_SLOTS)) u_snxt (
    .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
    .raddr(s_raddr), .rdata(sn_rdata)
  );
  tlca_ram #(.W(VW), .D(MAX_VERTICES)) u_stack (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  assign v_rdata  = vrow_t'(v_rdata_raw);
  assign sd_rdata = sdat_t'(sd_rdata_raw);

  assign add_room  = ({1'b0, fill_r} + (SW+1)'(2)) <= (SW+1)'(ADJ_SLOTS);
  assign pop_ok    = (top_r != '0) && (pops_r != (VW+1)'(MAX_VERTICES));
  assign vi_last   = vi_r == VW'(MAX_VERTICES - 1);
  assign fill_last = vi_last && (k_r == KW'(LOG_LEVELS - 1));
  assign k_prev    = k_r - KW'(1);
  assign top_dec   = top_r - (VW+1)'(1);
  assign link_ok   = (v_rdata.anc[0] != {1'b0, cur_r}) && (cur_anc0_r != {1'b0, nx_r});
  assign w_anc     = v_rdata.anc[k_r];
  assign up_anc    = v_rdata.anc[k_prev];
  assign meet_pair = (au_r != w_anc) && (au_r != ANC_NIL) && (w_anc != ANC_NIL);
  assign d_full    = {1'b0, dsum_r} - {2'b00, dm_r, 1'b0};
  assign d_clamp   = d_full[DEPW+2] ? '0 : d_full[PLW-1:0];
  assign probe_sum = {1'b0, dist1_r} + {1'b0, dist2_r};

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (vi_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ADD:   state_nxt = add_room ? S_A_RD : S_IDLE;
            OP_BUILD: state_nxt = S_W_INIT;
            OP_QUERY: state_nxt = S_M_RDU;
            OP_NONE:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_A_RD:    state_nxt = S_A_UPD;
      S_A_UPD:   state_nxt = half_r ? S_IDLE : S_A_RD;
      S_W_INIT:  state_nxt = S_W_POP;
      S_W_POP: begin
        if (pop_ok) state_nxt = S_W_CUR0;
        else        state_nxt = (LOG_LEVELS > 1) ? S_F_RD : S_IDLE;
      end
      S_W_CUR0:  state_nxt = S_W_CUR1;
      S_W_CUR1:  state_nxt = S_W_SLOT;
      S_W_SLOT:  state_nxt = (s_r == SLOT_NIL) ? S_W_POP : S_W_NB0;
      S_W_NB0:   state_nxt = S_W_NB1;
      S_W_NB1:   state_nxt = S_W_SLOT;
      S_F_RD:    state_nxt = S_F_UP;
      S_F_UP: begin
        if (up_anc != ANC_NIL) state_nxt = S_F_WR;
        else                   state_nxt = fill_last ? S_IDLE : S_F_RD;
      end
      S_F_WR:    state_nxt = fill_last ? S_IDLE : S_F_RD;
      S_M_RDU:   state_nxt = S_M_RDV;
      S_M_RDV:   state_nxt = S_M_SWP;
      S_M_SWP:   state_nxt = S_M_LIFT;
      S_M_LIFT: begin
        if (k_r == KW'(LOG_LEVELS)) state_nxt = S_M_CHK;
        else if (diff_r[k_r])       state_nxt = S_M_LIFT2;
      end
      S_M_LIFT2: state_nxt = (w_anc == ANC_NIL) ? S_M_CHK : S_M_LIFT;
      S_M_CHK:   state_nxt = (qu_r == qv_r) ? S_M_DONE : S_M_SRU;
      S_M_SRU:   state_nxt = S_M_SRV;
      S_M_SRV:   state_nxt = S_M_SRC;
      S_M_SRC:   state_nxt = (k_r == '0) ? S_M_FIN : S_M_SRU;
      S_M_FIN:   state_nxt = S_M_FIN2;
      S_M_FIN2:  state_nxt = S_M_DONE;
      S_M_DONE:  state_nxt = (meet_r == ANC_NIL) ? S_M_DIST : S_M_DM;
      S_M_DM:    state_nxt = S_M_DIST;
      S_M_DIST:  state_nxt = (pass_r == 2'd2) ? S_Q_OUT : S_M_RDU;
      S_Q_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vi_nxt = vi_r;  k_nxt = k_r;  fill_nxt = fill_r;  top_nxt = top_r;
    pops_nxt = pops_r;  cur_nxt = cur_r;  cur_anc0_nxt = cur_anc0_r;
    cur_depth_nxt = cur_depth_r;  s_nxt = s_r;  nx_nxt = nx_r;  num_nxt = num_r;
    src_nxt = src_r;  dst_nxt = dst_r;  half_nxt = half_r;
    ea_nxt = ea_r;  eb_nxt = eb_r;  ep_nxt = ep_r;  enum_nxt = enum_r;
    row_nxt = row_r;  qu_nxt = qu_r;  qv_nxt = qv_r;  du_nxt = du_r;
    diff_nxt = diff_r;  dsum_nxt = dsum_r;  meet_nxt = meet_r;  meet0_nxt = meet0_r;
    dm_nxt = dm_r;  au_nxt = au_r;  pass_nxt = pass_r;
    dist0_nxt = dist0_r;  dist1_nxt = dist1_r;  dist2_nxt = dist2_r;
    a_anc0_nxt = a_anc0_r;  a_pedge_nxt = a_pedge_r;  a_depth_nxt = a_depth_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt = out_res_r;
    v_we = 1'b0;  v_waddr = vi_r;  v_wdata = row_r;  v_raddr = vi_r;
    sd_we = 1'b0;  sd_waddr = fill_r;  sd_wdata = '{nbr: dst_r, num: enum_r};
    sn_we = 1'b0;  sn_waddr = fill_r;  sn_wdata = SLOT_NIL;  s_raddr = s_r;
    k_we = 1'b0;  k_waddr = top_r[VW-1:0];  k_wdata = nx_r;
    k_raddr = top_dec[VW-1:0];

    unique case (state_r)
      S_CLR: begin
        v_we = 1'b1;
        v_wdata = VROW_RESET;
        vi_nxt = vi_r + VW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          ea_nxt = in_a;  eb_nxt = in_b;  ep_nxt = in_p;  enum_nxt = in_num;
          src_nxt = in_a;  dst_nxt = in_b;  half_nxt = 1'b0;
          qu_nxt = in_a;  qv_nxt = in_b;  pass_nxt = 2'd0;
        end
      end
      S_A_RD: begin
        v_raddr = src_r;
        sd_we = 1'b1;
        sn_we = 1'b1;
      end
      S_A_UPD: begin
        v_wdata = v_rdata;
        if (v_rdata.head == SLOT_NIL) begin
          v_wdata.head = fill_r;
        end else begin
          sn_we = 1'b1;
          sn_waddr = v_rdata.tail;
          sn_wdata = fill_r;
        end
        v_wdata.tail = fill_r;
        v_we = 1'b1;
        v_waddr = src_r;
        fill_nxt = fill_r + SW'(1);
        half_nxt = 1'b1;
        src_nxt = dst_r;
        dst_nxt = src_r;
      end
      S_W_INIT: begin
        k_we = 1'b1;
        k_waddr = '0;
        k_wdata = root;
        top_nxt = (VW+1)'(1);
        pops_nxt = '0;
      end
      S_W_POP: begin
        if (pop_ok) begin
          top_nxt = top_r - (VW+1)'(1);
          pops_nxt = pops_r + (VW+1)'(1);
        end else begin
          vi_nxt = '0;
          k_nxt = KW'(1);
        end
      end
      S_W_CUR0: begin
        cur_nxt = k_rdata;
        v_raddr = k_rdata;
      end
      S_W_CUR1: begin
        cur_anc0_nxt = v_rdata.anc[0];
        cur_depth_nxt = v_rdata.depth;
        s_nxt = v_rdata.head;
      end
      S_W_SLOT: s_raddr = s_r;
      S_W_NB0: begin
        nx_nxt = sd_rdata.nbr;
        num_nxt = sd_rdata.num;
        s_nxt = sn_rdata;
        v_raddr = sd_rdata.nbr;
      end
      S_W_NB1: begin
        if (link_ok) begin
          v_wdata = v_rdata;
          v_wdata.anc[0] = {1'b0, cur_r};
          v_wdata.pedge = {1'b0, num_r};
          v_wdata.depth = cur_depth_r + DEPW'(1);
          v_we = 1'b1;
          v_waddr = nx_r;
          if (top_r != (VW+1)'(MAX_VERTICES)) begin
            k_we = 1'b1;
            top_nxt = top_r + (VW+1)'(1);
          end
          if (nx_r == cur_r) begin
            cur_anc0_nxt = {1'b0, cur_r};
            cur_depth_nxt = cur_depth_r + DEPW'(1);
          end
        end
      end
      S_F_RD: v_raddr = vi_r;
      S_F_UP: begin
        row_nxt = v_rdata;
        if (up_anc == ANC_NIL) begin
          v_wdata = v_rdata;
          v_wdata.anc[k_r] = ANC_NIL;
          v_we = 1'b1;
          vi_nxt = vi_r + VW'(1);
          if (vi_last) k_nxt = k_r + KW'(1);
        end else begin
          v_raddr = up_anc[VW-1:0];
        end
      end
      S_F_WR: begin
        v_wdata = row_r;
        v_wdata.anc[k_r] = up_anc;
        v_we = 1'b1;
        vi_nxt = vi_r + VW'(1);
        if (vi_last) k_nxt = k_r + KW'(1);
      end
      S_M_RDU: v_raddr = qu_r;
      S_M_RDV: begin
        du_nxt = v_rdata.depth;
        if (pass_r == 2'd0) begin
          a_anc0_nxt = v_rdata.anc[0];
          a_pedge_nxt = v_rdata.pedge;
          a_depth_nxt = v_rdata.depth;
        end
        v_raddr = qv_r;
      end
      S_M_SWP: begin
        dsum_nxt = {2'b00, du_r} + {2'b00, v_rdata.depth};
        if (du_r > v_rdata.depth) begin
          qu_nxt = qv_r;
          qv_nxt = qu_r;
          diff_nxt = du_r - v_rdata.depth;
        end else begin
          diff_nxt = v_rdata.depth - du_r;
        end
        k_nxt = '0;
      end
      S_M_LIFT: begin
        v_raddr = qv_r;
        if (k_r != KW'(LOG_LEVELS) && !diff_r[k_r]) k_nxt = k_r + KW'(1);
      end
      S_M_LIFT2: begin
        if (w_anc != ANC_NIL) begin
          qv_nxt = w_anc[VW-1:0];
          k_nxt = k_r + KW'(1);
        end
      end
      S_M_CHK: begin
        meet_nxt = {1'b0, qu_r};
        k_nxt = KW'(LOG_LEVELS - 1);
      end
      S_M_SRU: v_raddr = qu_r;
      S_M_SRV: begin
        au_nxt = w_anc;
        v_raddr = qv_r;
      end
      S_M_SRC: begin
        if (meet_pair) begin
          qu_nxt = au_r[VW-1:0];
          qv_nxt = w_anc[VW-1:0];
        end
        k_nxt = k_r - KW'(1);
      end
      S_M_FIN:  v_raddr = qu_r;
      S_M_FIN2: meet_nxt = v_rdata.anc[0];
      S_M_DONE: begin
        dm_nxt = '0;
        v_raddr = meet_r[VW-1:0];
      end
      S_M_DM:   dm_nxt = v_rdata.depth;
      S_M_DIST: begin
        pass_nxt = pass_r + 2'd1;
        unique case (pass_r)
          2'd0: begin
            dist0_nxt = d_clamp;
            meet0_nxt = meet_r;
            qu_nxt = ea_r;
            qv_nxt = ep_r;
          end
          2'd1: begin
            dist1_nxt = d_clamp;
            qu_nxt = ep_r;
            qv_nxt = eb_r;
          end
          default: dist2_nxt = d_clamp;
        endcase
      end
      S_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt.lca_vertex = (meet0_r == ANC_NIL) ? '0 : meet0_r[FW-1:0];
          out_res_nxt.path_length = dist0_r;
          out_res_nxt.probe_on_path = probe_sum == {1'b0, dist0_r};
          out_res_nxt.has_parent = a_anc0_r != ANC_NIL;
          out_res_nxt.parent_of_a = (a_anc0_r != ANC_NIL) ? a_anc0_r[FW-1:0] : '0;
          out_res_nxt.parent_edge_of_a = ((a_anc0_r != ANC_NIL) && (a_pedge_r != PEDGE_NIL))
                                         ? a_pedge_r[FW-1:0] : '0;
          out_res_nxt.depth_of_a = a_depth_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      vi_r        <= '0;
      k_r         <= '0;
      fill_r      <= '0;
      top_r       <= '0;
      pops_r      <= '0;
      pass_r      <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vi_r        <= vi_nxt;
      k_r         <= k_nxt;
      fill_r      <= fill_nxt;
      top_r       <= top_nxt;
      pops_r      <= pops_nxt;
      pass_r      <= pass_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;  cur_anc0_r <= cur_anc0_nxt;  cur_depth_r <= cur_depth_nxt;
    s_r <= s_nxt;  nx_r <= nx_nxt;  num_r <= num_nxt;
    src_r <= src_nxt;  dst_r <= dst_nxt;
    ea_r <= ea_nxt;  eb_r <= eb_nxt;  ep_r <= ep_nxt;  enum_r <= enum_nxt;
    row_r <= row_nxt;  qu_r <= qu_nxt;  qv_r <= qv_nxt;  du_r <= du_nxt;
    diff_r <= diff_nxt;  dsum_r <= dsum_nxt;  meet_r <= meet_nxt;  meet0_r <= meet0_nxt;
    dm_r <= dm_nxt;  au_r <= au_nxt;
    dist0_r <= dist0_nxt;  dist1_r <= dist1_nxt;  dist2_r <= dist2_nxt;
    a_anc0_r <= a_anc0_nxt;  a_pedge_r <= a_pedge_nxt;  a_depth_r <= a_depth_nxt;
    out_res_r <= out_res_nxt;
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= (VW+1)'(MAX_VERTICES))
    else $error("walk stack pointer beyond its depth");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= (SW+1)'(ADJ_SLOTS))
    else $error("adjacency fill count beyond the slot count");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_Q_OUT))
    else $error("result word raised outside the output step");

  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("input taken during the clearing pass");

endmodule

// ===== rtl/tree_lca_binary_lifting_core.sv =====
// Top level of the tree LCA engine: stream channels and register port.
//
// Add-edge, build and query words enter on the in_ channel; only a query
// gives a result word on the out_ channel. op travels in in_tuser.
// After reset a clearing pass initializes the vertex memory;
// in_tready stays low during it, register writes are taken as ever.
// One item is worked at a time; the vertex memory has a single read port,
// so the sequencer takes its reads of it one after another.
// An add-edge word reads and updates the vertex row of each end in turn.
// A build walks the tree from the root with a stack, visiting every
// half-edge of each popped vertex, then fills the ancestor table vertex
// by vertex and level by level. A query runs three LCA walks (a with b,
// a with the probe, the probe with b) and then presents the result.
// A finished result waits in an output register; the next item is accepted
// meanwhile, and a later query holds at its output step until out_tready.
// The root register is written over an APB port at byte address 0 and
// must only change while the block is idle.
module tree_lca_binary_lifting_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tlca_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [39:0]                in_tdata,   // vert_a, vert_b, edge_index, probe_vertex
  input  logic [1:0]                 in_tuser,   // op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [55:0]                out_tdata   // lca_vertex, path_length, probe_on_path,
                                                 // has_parent, parent_of_a,
                                                 // parent_edge_of_a, depth_of_a
);
  import tlca_pkg::*;

  logic [VW-1:0] root_r;
  logic [0:0]    reg_idx;
  result_t       res;

  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_ROOT) ? {{(32-VW){1'b0}}, root_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && reg_idx == REG_ROOT) begin
      root_r <= cfg_pwdata[VW-1:0];
    end
  end

  tlca_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .root      (root_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_a      (in_tdata[VW-1:0]),
    .in_b      (in_tdata[FW+VW-1:FW]),
    .in_num    (in_tdata[3*FW-1:2*FW]),
    .in_p      (in_tdata[3*FW+VW-1:3*FW]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'b000, res.depth_of_a, res.parent_edge_of_a, res.parent_of_a,
                      res.has_parent, res.probe_on_path, res.path_length,
                      res.lca_vertex};

endmodule
